@@ design/counter_hash_random_generator_defines.svh @@
// assertion macros for the counter hash random generator checker
// needs signals clk and rst in the scope where a macro is used
`ifndef COUNTER_HASH_RANDOM_GENERATOR_DEFINES_SVH
`define COUNTER_HASH_RANDOM_GENERATOR_DEFINES_SVH

// same-cycle implication
`define CHRG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chrg assertion failed");

// next-cycle implication
`define CHRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chrg assertion failed");

`endif

@@ design/chrg_pkg.sv @@
// package for the counter hash random generator
// round keys, register selects and sequencer state type; no dependencies
`default_nettype none

package chrg_pkg;

  localparam int ROUND_COUNT_DEF = 4;
  localparam int WORD_W = 32;
  localparam int HALF_W = 16;

  localparam logic REG_SEED  = 1'b0;
  localparam logic REG_START = 1'b1;

  localparam logic [WORD_W-1:0] KEY_IN [4] = '{
    32'hbaa96887, 32'h1e17d32c, 32'h03bcdc3c, 32'h0f33d1b2
  };
  localparam logic [WORD_W-1:0] KEY_OUT [4] = '{
    32'h4b0f3b58, 32'he874f0c3, 32'h6955c5a6, 32'h55a7ca46
  };

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_MIX  = 3'b100
  } state_t;

endpackage

`default_nettype wire

@@ design/counter_hash_random_generator.sv @@
// counter hash random generator: pseudo-des feistel hash of (seed, counter)
// depends on chrg_pkg
//
// usage: write seed_word at paddr 0 and start_index at paddr 4 over the apb
// port while the block is idle; writing start_index also reloads the counter.
// each item on the input channel with request high yields one random_word
// on the output channel and advances the counter by one (wrapping at 2^32);
// an item with request low is taken and yields nothing.
// one shared set of 16x16 multipliers runs each feistel round as a products step
// (S_MUL) and then a mix step (S_MIX); in_ready is low from the time a request
// item is taken until its result is registered, so a new item is taken only
// once the last one is through.
// the result sits in an output register; if the receiver stalls, the block
// can take one more item and then holds its last round until the register
// empties. reset clears seed_word, start_index and the counter to zero and
// leaves both channels empty.
`default_nettype none

module counter_hash_random_generator
  import chrg_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              request,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [WORD_W-1:0] random_word
);

  localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RW-1:0] LAST_ROUND = RW'(ROUND_COUNT - 1);

  state_t state, state_next;
  logic [RW-1:0] round_cnt;
  logic [WORD_W-1:0] seed_word, start_index, counter;
  logic [WORD_W-1:0] high, low;
  logic [WORD_W-1:0] prod_aa, prod_bb, prod_ab;

  logic cfg_wr, in_acc, last_done;
  logic [WORD_W-1:0] t_word, s_sum, s_rot, high_next;
  logic [HALF_W-1:0] half_a, half_b;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_START) ? start_index : seed_word;
  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign t_word    = high ^ KEY_IN[2'(round_cnt)];
  assign half_a    = t_word[HALF_W-1:0];
  assign half_b    = t_word[WORD_W-1:HALF_W];
  assign s_sum     = prod_aa + ~prod_bb;
  assign s_rot     = {s_sum[HALF_W-1:0], s_sum[WORD_W-1:HALF_W]};
  assign high_next = low ^ ((s_rot ^ KEY_OUT[2'(round_cnt)]) + prod_ab);
  assign last_done = (state == S_MIX) && (round_cnt == LAST_ROUND)
                     && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && request) state_next = S_MUL;
      end
      S_MUL: state_next = S_MIX;
      S_MIX: begin
        if (round_cnt != LAST_ROUND) state_next = S_MUL;
        else if (last_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      round_cnt   <= '0;
      seed_word   <= '0;
      start_index <= '0;
      counter     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        if (paddr[2] == REG_SEED) begin
          seed_word <= pwdata;
        end else begin
          start_index <= pwdata;
          counter     <= pwdata;
        end
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: round_cnt <= '0;
        S_MIX: begin
          if (round_cnt != LAST_ROUND) begin
            round_cnt <= round_cnt + RW'(1);
          end else if (last_done) begin
            out_valid <= 1'b1;
            counter   <= counter + WORD_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          high <= counter;
          low  <= seed_word;
        end
      end
      S_MUL: begin
        prod_aa <= WORD_W'(half_a) * WORD_W'(half_a);
        prod_bb <= WORD_W'(half_b) * WORD_W'(half_b);
        prod_ab <= WORD_W'(half_a) * WORD_W'(half_b);
      end
      S_MIX: begin
        if (round_cnt != LAST_ROUND || last_done) begin
          high <= high_next;
          low  <= high;
        end
        if (last_done) random_word <= high_next;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/chrg_checker.sv @@
// port-level checker for the counter hash random generator, with its bind
// depends on counter_hash_random_generator_defines.svh
`default_nettype none
`include "counter_hash_random_generator_defines.svh"

module chrg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        request,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] random_word
);

  `CHRG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(random_word))
  `CHRG_ASSERT_NEXT(a_busy_after_item, in_valid && in_ready && request, !in_ready)
  `CHRG_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && request, !$rose(out_valid))
  `CHRG_ASSERT_IMPL(a_idle_on_result, $rose(out_valid), in_ready)

endmodule

bind counter_hash_random_generator chrg_checker u_chrg_checker (.*);

`default_nettype wire

@@ verif/random_word_checker.sv @@
// checker for the counter hash random generator: watches the apb port and both
// item channels, predicts each random_word and compares it in order
// depends on chrg_pkg
module random_word_checker
  import chrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        request,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] random_word,
  output int          fail_count,
  output int          outstanding
);

  logic [31:0] seed_model;
  logic [31:0] counter_model;
  logic [31:0] expected_words[$];

  initial begin
    fail_count = 0;
    outstanding = 0;
    seed_model = '0;
    counter_model = '0;
  end

  function automatic logic [31:0] psdes_hash(input logic [31:0] lo_in, input logic [31:0] hi_in);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    logic [31:0] keep;
    lo = lo_in;
    hi = hi_in;
    for (int r = 0; r < ROUND_COUNT_DEF; r++) begin
      keep = hi;
      t = hi ^ KEY_IN[r];
      a = {16'h0, t[15:0]};
      b = {16'h0, t[31:16]};
      s = (a * a) + ~(b * b);
      s = {s[15:0], s[31:16]};
      hi = lo ^ ((s ^ KEY_OUT[r]) + (a * b));
      lo = keep;
    end
    return hi;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin
    int pushed;
    int popped;
    logic [31:0] want;
    pushed = 0;
    popped = 0;
    if (rst) begin
      seed_model = '0;
      counter_model = '0;
      expected_words.delete();
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready && request) begin
        expected_words.push_back(psdes_hash(seed_model, counter_model));
        counter_model = counter_model + 32'd1;
        pushed = 1;
      end
      if (out_valid && out_ready) begin
        popped = 1;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected random_word", random_word, '0);
        end else begin
          want = expected_words.pop_front();
          if (random_word !== want)
            report_mismatch("random_word", random_word, want);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_SEED, 2'b00}) begin
          seed_model = pwdata;
        end else if (paddr == {REG_START, 2'b00}) begin
          counter_model = pwdata;
        end
      end
      outstanding <= outstanding + pushed - popped;
    end
  end

endmodule

@@ verif/tb.sv @@
// testbench top for the counter hash random generator: apb setup, bursty
// request items, a stalling receiver and the final verdict
// depends on chrg_pkg, counter_hash_random_generator and random_word_checker
module tb;
  import chrg_pkg::*;

  localparam int ITEM_TARGET = 1200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 2 * ROUND_COUNT_DEF + 6;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        request = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] random_word;

  int fail_count;
  int outstanding;
  int cycles = 0;
  int requests_sent = 0;
  bit no_gaps = 1'b0;

  int rx_mode = 0;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  counter_hash_random_generator u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .request(request),
    .out_valid(out_valid), .out_ready(out_ready), .random_word(random_word)
  );

  random_word_checker u_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .request(request),
    .out_valid(out_valid), .out_ready(out_ready), .random_word(random_word),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(5, 30);
        end
      endcase
    end
    if ($urandom_range(0, 99) == 0) rx_mode <= $urandom_range(0, 3);
  end

  task automatic write_reg(input logic sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic req);
    in_valid <= 1'b1;
    request <= req;
    do @(posedge clk); while (!in_ready);
    if (req) requests_sent++;
  endtask

  // let every expected item come back, then give a request-low item time to finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_requests(input int count);
    int done;
    int burst_len;
    int gap;
    logic req;
    done = 0;
    while (done < count) begin
      burst_len = $urandom_range(1, 16);
      for (int k = 0; k < burst_len && done < count; k++) begin
        req = ($urandom_range(0, 9) != 0);
        send_item(req);
        if (req) done++;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'hffff_ffff - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, then a request-low item that must leave the counter alone
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
    drain();

    // all-ones seed and counter at its maximum so it wraps
    write_reg(REG_SEED, 32'hffff_ffff);
    write_reg(REG_START, 32'hffff_ffff);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b1);
    drain();

    // new seed alone keeps the counter running
    write_reg(REG_SEED, 32'h0000_0000);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    drain();

    // restart from a chosen index
    write_reg(REG_START, 32'h8000_0000);
    write_reg(REG_SEED, 32'ha5a5_a5a5);
    send_item(1'b1);
    send_item(1'b1);
    drain();

    write_reg(REG_START, 32'h0000_0000);
    write_reg(REG_SEED, 32'h5a5a_5a5a);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
    drain();

    while (requests_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) != 0) write_reg(REG_SEED, pick_word());
      if ($urandom_range(0, 2) != 0) write_reg(REG_START, pick_word());
      no_gaps = ($urandom_range(0, 3) == 0);
      run_requests($urandom_range(30, 150));
      drain();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
